### sv/colon_tag_line_scanner_top_defines.svh
// assertion macros for the colon tag line scanner checker
// expects signals named clock and reset in the scope of each use
`ifndef COLON_TAG_LINE_SCANNER_TOP_DEFINES_SVH
`define COLON_TAG_LINE_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define CTS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cts checker: same-cycle property violated");

// next-cycle implication, held off during reset
`define CTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cts checker: next-cycle property violated");

`endif

### sv/cts_pkg.sv
// shared types and constants for the colon tag line scanner
// no dependencies
`default_nettype none

package cts_pkg;

   localparam int LOOKAHEAD = 4;
   localparam int FILL_BITS = 3;
   localparam int COUNT_BITS = 16;
   localparam int OUT_OFF_BITS = 16;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = 2;
   localparam int QCNT_BITS = 3;

   // event codes
   localparam logic [1:0] EV_TAG = 2'd0;
   localparam logic [1:0] EV_BODY = 2'd1;
   localparam logic [1:0] EV_END = 2'd2;

   // characters of interest
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_RETURN = 8'h0D;
   localparam logic [7:0] CH_VTAB = 8'h0B;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      SCAN_HUNTING,
      SCAN_IN_NAME,
      SCAN_IN_VALUE,
      SCAN_DONE
   } scan_state_type;

   typedef struct packed {
      logic [1:0]                event_res;
      logic [OUT_OFF_BITS-1:0]   start_offset;
      logic [OUT_OFF_BITS-1:0]   colon_offset;
      logic [COUNT_BITS-1:0]     tag_count;
      logic                      overflow;
      logic                      final_res;
   } rsp_type;

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_UNDERSCORE) || (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_EQUAL);
   endfunction

   // space, tab, newline, vtab, form feed, return
   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_RETURN));
   endfunction

endpackage

`default_nettype wire

### sv/cts_ifs.sv
// valid/ready channel interfaces for the colon tag line scanner
// depends on cts_pkg for field widths
`default_nettype none

interface cts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface cts_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            event_res;
   logic [cts_pkg::OUT_OFF_BITS-1:0]      start_offset;
   logic [cts_pkg::OUT_OFF_BITS-1:0]      colon_offset;
   logic [cts_pkg::COUNT_BITS-1:0]        tag_count;
   logic                                  overflow;
   logic                                  final_res;

   modport source (output valid, output event_res, output start_offset, output colon_offset,
                   output tag_count, output overflow, output final_res, input ready);
   modport sink (input valid, input event_res, input start_offset, input colon_offset,
                 input tag_count, input overflow, input final_res, output ready);
endinterface

`default_nettype wire

### sv/colon_tag_line_scanner_top.sv
// colon tag line scanner: header tag and body marker finder over a byte stream
// depends on cts_pkg and the channel interfaces in cts_ifs.sv
//
//  channel   | dir | payload                                        | per transfer
//  ----------+-----+------------------------------------------------+--------------------
//  req_ch    | in  | data_byte, last                                | one record byte
//  rsp_ch    | out | event_res, start_offset, colon_offset,         | one result
//            |     | tag_count, overflow, final_res                 |
//
// one byte per cycle while ready is high; scan state, window, offsets update on each transfer
// a byte gives zero, one or two results, written into a four-entry result queue
// req_ch.ready is high while the queue has room for two results, so a stalled rsp side
// holds the input back only once three or more results are waiting
// synchronous reset clears the scan state and empties the queue; no clearing pass
`default_nettype none

module colon_tag_line_scanner_top #(
   parameter int OFFSET_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cts_req_if.sink    req_ch,
   cts_rsp_if.source  rsp_ch
);

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
   localparam logic [cts_pkg::COUNT_BITS-1:0] COUNT_MAX = {cts_pkg::COUNT_BITS{1'b1}};

   // scan state
   logic [7:0]                          win_ff [cts_pkg::LOOKAHEAD];
   logic [cts_pkg::FILL_BITS-1:0]       fill_ff;
   cts_pkg::scan_state_type             state_ff, state_in;
   logic [OFFSET_BITS-1:0]              pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]              name_start_ff, name_start_in;
   logic [cts_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   logic                                exc_ff, exc_in;

   // result queue
   cts_pkg::rsp_type                    q_ff [cts_pkg::QUEUE_DEPTH];
   logic [cts_pkg::QPTR_BITS-1:0]       head_ff, tail_ff;
   logic [cts_pkg::QCNT_BITS-1:0]       qcnt_ff;

   logic       req_fire, rsp_fire, scan_en, scan_live;
   logic [7:0] cur;
   logic       body_hit, tag_hit, name_begin;
   cts_pkg::rsp_type scan_res, end_res, first_res;
   logic       push_one, push_two;
   logic [cts_pkg::QCNT_BITS-1:0] n_push;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (qcnt_ff <= cts_pkg::QCNT_BITS'(cts_pkg::QUEUE_DEPTH - 2));

   // oldest window byte is scanned once the window is full
   assign scan_en = (fill_ff == cts_pkg::FILL_BITS'(cts_pkg::LOOKAHEAD));
   assign cur = win_ff[0];
   assign scan_live = scan_en && (cur != cts_pkg::CH_RETURN) && (cur != cts_pkg::CH_VTAB);

   // next state
   always_comb begin
      state_in = state_ff;
      if (scan_live) begin
         case (state_ff)
            cts_pkg::SCAN_HUNTING: begin
               if ((cur == cts_pkg::CH_NEWLINE) ||
                   (cts_pkg::is_sep(cur) && cts_pkg::is_sep(win_ff[1]) &&
                    cts_pkg::is_sep(win_ff[2]) && cts_pkg::is_sep(win_ff[3]))) begin
                  state_in = cts_pkg::SCAN_DONE;
               end else if (!cts_pkg::is_blank(cur)) begin
                  state_in = cts_pkg::SCAN_IN_NAME;
               end
            end
            cts_pkg::SCAN_IN_NAME: begin
               if ((cur == cts_pkg::CH_SPACE) || (cur == cts_pkg::CH_TAB) ||
                   (cur == cts_pkg::CH_COLON)) begin
                  state_in = cts_pkg::SCAN_IN_VALUE;
               end
            end
            cts_pkg::SCAN_IN_VALUE: begin
               if (cur == cts_pkg::CH_NEWLINE) begin
                  state_in = cts_pkg::SCAN_HUNTING;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   // scan outputs
   always_comb begin
      body_hit = 1'b0;
      tag_hit = 1'b0;
      name_begin = 1'b0;
      if (scan_live) begin
         case (state_ff)
            cts_pkg::SCAN_HUNTING: begin
               if ((cur == cts_pkg::CH_NEWLINE) ||
                   (cts_pkg::is_sep(cur) && cts_pkg::is_sep(win_ff[1]) &&
                    cts_pkg::is_sep(win_ff[2]) && cts_pkg::is_sep(win_ff[3]))) begin
                  body_hit = 1'b1;
               end else if (!cts_pkg::is_blank(cur)) begin
                  name_begin = 1'b1;
               end
            end
            cts_pkg::SCAN_IN_NAME: begin
               tag_hit = (cur == cts_pkg::CH_COLON);
            end
            default: begin
               body_hit = 1'b0;
            end
         endcase
      end
   end

   // counters and offsets after this byte
   always_comb begin
      count_in = count_ff;
      if (tag_hit && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end
      pos_in = pos_ff;
      exc_in = exc_ff;
      if (scan_en) begin
         if (pos_ff != OFF_MAX) begin
            pos_in = pos_ff + 1'b1;
         end else begin
            exc_in = 1'b1;
         end
      end
      name_start_in = name_begin ? pos_ff : name_start_ff;
   end

   // result words
   always_comb begin
      scan_res.event_res = tag_hit ? cts_pkg::EV_TAG : cts_pkg::EV_BODY;
      scan_res.start_offset = tag_hit ? 16'(32'(name_start_ff)) : 16'(32'(pos_ff));
      scan_res.colon_offset = 16'(32'(pos_ff));
      scan_res.tag_count = count_in;
      scan_res.overflow = exc_ff;
      scan_res.final_res = !req_ch.last;

      end_res.event_res = cts_pkg::EV_END;
      end_res.start_offset = 16'(32'(pos_in));
      end_res.colon_offset = 16'(32'(pos_in));
      end_res.tag_count = count_in;
      end_res.overflow = exc_in;
      end_res.final_res = 1'b1;

      first_res = (tag_hit || body_hit) ? scan_res : end_res;
      push_one = req_fire && (tag_hit || body_hit || req_ch.last);
      push_two = req_fire && (tag_hit || body_hit) && req_ch.last;
      n_push = {1'b0, push_two, push_one && !push_two};
   end

   // scan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cts_pkg::LOOKAHEAD; i++) begin
            win_ff[i] <= 8'd0;
         end
         fill_ff <= '0;
         state_ff <= cts_pkg::SCAN_HUNTING;
         pos_ff <= '0;
         name_start_ff <= '0;
         count_ff <= '0;
         exc_ff <= 1'b0;
      end else if (req_fire) begin
         if (req_ch.last) begin
            // record end returns to the reset state
            for (int i = 0; i < cts_pkg::LOOKAHEAD; i++) begin
               win_ff[i] <= 8'd0;
            end
            fill_ff <= '0;
            state_ff <= cts_pkg::SCAN_HUNTING;
            pos_ff <= '0;
            name_start_ff <= '0;
            count_ff <= '0;
            exc_ff <= 1'b0;
         end else begin
            if (scan_en) begin
               for (int i = 0; i < cts_pkg::LOOKAHEAD - 1; i++) begin
                  win_ff[i] <= win_ff[i+1];
               end
               win_ff[cts_pkg::LOOKAHEAD-1] <= req_ch.data_byte;
            end else begin
               win_ff[fill_ff[cts_pkg::FILL_BITS-2:0]] <= req_ch.data_byte;
               fill_ff <= fill_ff + 1'b1;
            end
            state_ff <= state_in;
            pos_ff <= pos_in;
            name_start_ff <= name_start_in;
            count_ff <= count_in;
            exc_ff <= exc_in;
         end
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (push_one) begin
         q_ff[tail_ff] <= first_res;
      end
      if (push_two) begin
         q_ff[tail_ff + 1'b1] <= end_res;
      end
   end

   // result queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         qcnt_ff <= '0;
      end else begin
         tail_ff <= tail_ff + n_push[cts_pkg::QPTR_BITS-1:0];
         if (rsp_fire) begin
            head_ff <= head_ff + 1'b1;
         end
         qcnt_ff <= qcnt_ff + n_push - {{(cts_pkg::QCNT_BITS-1){1'b0}}, rsp_fire};
      end
   end

   assign rsp_ch.valid = (qcnt_ff != '0);
   assign rsp_ch.event_res = q_ff[head_ff].event_res;
   assign rsp_ch.start_offset = q_ff[head_ff].start_offset;
   assign rsp_ch.colon_offset = q_ff[head_ff].colon_offset;
   assign rsp_ch.tag_count = q_ff[head_ff].tag_count;
   assign rsp_ch.overflow = q_ff[head_ff].overflow;
   assign rsp_ch.final_res = q_ff[head_ff].final_res;

endmodule

`default_nettype wire

### sv/cts_checker.sv
// port-level checks on the colon tag line scanner result channel
// depends on cts_pkg and colon_tag_line_scanner_top_defines.svh; bound to the top level
`default_nettype none
`include "colon_tag_line_scanner_top_defines.svh"

module cts_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [1:0]                          event_res,
   input wire logic [cts_pkg::OUT_OFF_BITS-1:0]    start_offset,
   input wire logic [cts_pkg::OUT_OFF_BITS-1:0]    colon_offset,
   input wire logic [cts_pkg::COUNT_BITS-1:0]      tag_count,
   input wire logic                                final_res
);

   // a waiting result holds until the transfer
   `CTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(event_res) && $stable(start_offset) && $stable(colon_offset) && $stable(tag_count))

   // record end always closes the results of its byte
   `CTS_ASSERT_NOW(a_end_final, rsp_valid && (event_res == cts_pkg::EV_END), final_res)

   // body marker and record end report a single offset twice
   `CTS_ASSERT_NOW(a_same_offset, rsp_valid && (event_res != cts_pkg::EV_TAG), start_offset == colon_offset)

   // a tag result counts itself
   `CTS_ASSERT_NOW(a_tag_counted, rsp_valid && (event_res == cts_pkg::EV_TAG), tag_count != '0)

endmodule

bind colon_tag_line_scanner_top cts_checker u_cts_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .event_res    (rsp_ch.event_res),
   .start_offset (rsp_ch.start_offset),
   .colon_offset (rsp_ch.colon_offset),
   .tag_count    (rsp_ch.tag_count),
   .final_res    (rsp_ch.final_res)
);

`default_nettype wire
